@@ hw/rtl/mi3_pkg.sv @@
// ----------------------------------------------------------------------------
// mi3_pkg
// Shared widths and types of the 3x3 matrix inverse datapath.
// ----------------------------------------------------------------------------
package mi3_pkg;

	// element width (signed fixed point)
	localparam int EW  = 32;
	// element product width
	localparam int PW  = 64;
	// signed cofactor width
	localparam int CW  = 65;
	// cofactor magnitude width
	localparam int MW  = 64;
	// signed determinant width and magnitude width
	localparam int DSW = 98;
	localparam int DW  = 96;
	// quotient bits kept: 32 result bits plus one for the clamp check
	localparam int QB  = 33;
	// divider remainder width
	localparam int RW  = DW + QB + 1;

	typedef logic [8:0][EW-1:0] mat_t;
	typedef logic [8:0][MW-1:0] cof_mag_t;

	// determinant summary handed from the cofactor pipe to the divider
	typedef struct packed {
		logic          neg;
		logic          zero;
		logic [DW-1:0] mag;
	} det_info_t;

endpackage

@@ hw/rtl/mi3_cofactor.sv @@
// ----------------------------------------------------------------------------
// mi3_cofactor
// Five-stage pipe: minor products, signed cofactors, determinant partial
// products, determinant sum, magnitudes and signs.
// ----------------------------------------------------------------------------
module mi3_cofactor
	import mi3_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  logic      in_vld,
	input  mat_t      in_mat,
	output logic      out_vld,
	output mat_t      out_mat,
	output cof_mag_t  out_cof_mag,
	output logic [8:0] out_cof_neg,
	output det_info_t out_det
);

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	mat_t mat_s1, mat_s2, mat_s3, mat_s4, mat_s5;

	logic signed [PW-1:0] pa_s1 [9];
	logic signed [PW-1:0] pb_s1 [9];
	logic signed [CW-1:0] cof_s2 [9];
	logic signed [CW-1:0] cof_s3 [9];
	logic signed [CW-1:0] cof_s4 [9];
	logic signed [CW:0]   plo_s3 [3];
	logic signed [CW:0]   phi_s3 [3];
	logic signed [DSW-1:0] det_s4;
	logic signed [DSW-1:0] det_sum;
	cof_mag_t   cof_mag_s5;
	logic [8:0] cof_neg_s5;
	det_info_t  det_s5;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// matrix travels along for the singular echo
	always_ff @(posedge clk) begin
		if (en) begin
			mat_s1 <= in_mat;
			mat_s2 <= mat_s1;
			mat_s3 <= mat_s2;
			mat_s4 <= mat_s3;
			mat_s5 <= mat_s4;
		end
	end

	// minor products and signed cofactors
	for (genvar k = 0; k < 9; k++) begin : g_cof
		localparam int R  = k / 3;
		localparam int C  = k % 3;
		localparam int R0 = (R == 0) ? 1 : 0;
		localparam int R1 = (R == 2) ? 1 : 2;
		localparam int C0 = (C == 0) ? 1 : 0;
		localparam int C1 = (C == 2) ? 1 : 2;
		localparam bit ODD = ((R + C) % 2) == 1;

		always_ff @(posedge clk) begin
			if (en) begin
				pa_s1[k] <= $signed(in_mat[R0*3+C0]) * $signed(in_mat[R1*3+C1]);
				pb_s1[k] <= $signed(in_mat[R0*3+C1]) * $signed(in_mat[R1*3+C0]);
				if (ODD) begin
					cof_s2[k] <= CW'(pb_s1[k]) - CW'(pa_s1[k]);
				end else begin
					cof_s2[k] <= CW'(pa_s1[k]) - CW'(pb_s1[k]);
				end
				cof_s3[k] <= cof_s2[k];
				cof_s4[k] <= cof_s3[k];
				cof_neg_s5[k] <= cof_s4[k][CW-1];
				cof_mag_s5[k] <= cof_s4[k][CW-1] ? MW'(-cof_s4[k]) : MW'(cof_s4[k]);
			end
		end
	end

	// determinant partial products along row 0, cofactor split in two halves
	for (genvar c = 0; c < 3; c++) begin : g_det
		always_ff @(posedge clk) begin
			if (en) begin
				plo_s3[c] <= $signed(mat_s2[c]) * $signed({1'b0, cof_s2[c][31:0]});
				phi_s3[c] <= $signed(mat_s2[c]) * $signed(cof_s2[c][CW-1:32]);
			end
		end
	end

	// determinant sum
	always_comb begin
		det_sum = '0;
		for (int c = 0; c < 3; c++) begin
			det_sum = det_sum + (DSW'(phi_s3[c]) <<< 32) + DSW'(plo_s3[c]);
		end
	end

	// determinant magnitude and sign
	always_ff @(posedge clk) begin
		if (en) begin
			det_s4      <= det_sum;
			det_s5.neg  <= det_s4[DSW-1];
			det_s5.zero <= (det_s4 == '0);
			det_s5.mag  <= det_s4[DSW-1] ? DW'(-det_s4) : DW'(det_s4);
		end
	end

	assign out_vld     = vld_s5;
	assign out_mat     = mat_s5;
	assign out_cof_mag = cof_mag_s5;
	assign out_cof_neg = cof_neg_s5;
	assign out_det     = det_s5;

endmodule

@@ hw/rtl/mi3_div.sv @@
// ----------------------------------------------------------------------------
// mi3_div
// Nine-lane pipelined restoring divider, one quotient bit per stage, with
// an overflow check in its first stage. Lanes come out transposed.
// ----------------------------------------------------------------------------
module mi3_div
	import mi3_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  logic      in_vld,
	input  mat_t      in_mat,
	input  cof_mag_t  in_cof_mag,
	input  logic [8:0] in_cof_neg,
	input  det_info_t in_det,
	output logic      out_vld,
	output mat_t      out_mat,
	output logic      out_zero,
	output logic [8:0] out_neg,
	output logic [8:0] out_ovf,
	output logic [8:0][QB-1:0] out_quo
);

	logic             vld_s [QB+1];
	mat_t             mat_s [QB+1];
	det_info_t        det_s [QB+1];
	logic [8:0]       neg_s [QB+1];
	logic [8:0]       ovf_s [QB+1];
	logic [8:0][QB-1:0] quo_s [QB+1];
	logic [8:0][RW-1:0] rem_s [QB];

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= QB; k++) vld_s[k] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_vld;
			for (int k = 1; k <= QB; k++) vld_s[k] <= vld_s[k-1];
		end
	end

	// stage 0: scaled numerator and overflow check, transposed lanes
	for (genvar l = 0; l < 9; l++) begin : g_s0
		localparam int SRC = (l % 3) * 3 + (l / 3);
		logic [RW-1:0] num;
		assign num = RW'(in_cof_mag[SRC]) << (2 * FRAC_BITS);

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[0][l] <= num;
				quo_s[0][l] <= '0;
				neg_s[0][l] <= in_cof_neg[SRC] ^ in_det.neg;
				ovf_s[0][l] <= num >= (RW'(in_det.mag) << QB);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mat_s[0] <= in_mat;
			det_s[0] <= in_det;
		end
	end

	// one quotient bit per stage, most significant first
	for (genvar k = 1; k <= QB; k++) begin : g_stage
		localparam int BIT = QB - k;

		always_ff @(posedge clk) begin
			if (en) begin
				mat_s[k] <= mat_s[k-1];
				det_s[k] <= det_s[k-1];
				neg_s[k] <= neg_s[k-1];
				ovf_s[k] <= ovf_s[k-1];
			end
		end

		for (genvar l = 0; l < 9; l++) begin : g_lane
			logic [RW:0] diff;
			assign diff = {1'b0, rem_s[k-1][l]} - ({1'b0, RW'(det_s[k-1].mag)} << BIT);

			always_ff @(posedge clk) begin
				if (en) begin
					quo_s[k][l] <= quo_s[k-1][l] | (QB'(!diff[RW]) << BIT);
				end
			end

			if (k < QB) begin : g_rem
				always_ff @(posedge clk) begin
					if (en) begin
						rem_s[k][l] <= diff[RW] ? rem_s[k-1][l] : diff[RW-1:0];
					end
				end
			end
		end
	end

	assign out_vld  = vld_s[QB];
	assign out_mat  = mat_s[QB];
	assign out_zero = det_s[QB].zero;
	assign out_neg  = neg_s[QB];
	assign out_ovf  = ovf_s[QB];
	assign out_quo  = quo_s[QB];

endmodule

@@ hw/rtl/matrix3_inverse_core.sv @@
// ----------------------------------------------------------------------------
// matrix3_inverse_core
// Inverse of a row-major 3x3 signed fixed-point matrix by the adjugate.
// ----------------------------------------------------------------------------
// One matrix is taken per clock and one result leaves per clock while the
// output is not stalled. The pipe runs cofactor and determinant arithmetic,
// an overflow check, restoring division (one quotient bit per stage, all
// nine elements in parallel) and one output register. The whole pipe moves
// together and holds while the output transaction is stalled.
// Results are truncated toward zero and clamped to 32 bits (tuser bit 1);
// a matrix with a zero determinant comes back unchanged with tuser bit 0 set.
module matrix3_inverse_core
	import mi3_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// a00, a01, a02, a10, a11, a12, a20, a21, a22 (32 bits each)
	input  logic [287:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// b00, b01, b02, b10, b11, b12, b20, b21, b22 (32 bits each)
	output logic [287:0] m_tdata,
	// singular, saturated
	output logic [1:0]   m_tuser
);

	logic       en;
	logic       cf_vld;
	mat_t       cf_mat;
	cof_mag_t   cf_mag;
	logic [8:0] cf_neg;
	det_info_t  cf_det;

	logic       dv_vld;
	mat_t       dv_mat;
	logic       dv_zero;
	logic [8:0] dv_neg;
	logic [8:0] dv_ovf;
	logic [8:0][QB-1:0] dv_quo;

	logic [8:0][EW-1:0] res;
	logic [8:0] lane_sat;

	logic       vld_q;
	mat_t       b_q;
	logic       singular_q;
	logic       saturated_q;

	// whole pipe advances unless the output holds a result not yet taken
	assign en       = !vld_q || m_tready;
	assign s_tready = en;

	mi3_cofactor u_cof (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_vld      (s_tvalid),
		.in_mat      (s_tdata),
		.out_vld     (cf_vld),
		.out_mat     (cf_mat),
		.out_cof_mag (cf_mag),
		.out_cof_neg (cf_neg),
		.out_det     (cf_det)
	);

	mi3_div #(
		.FRAC_BITS (FRAC_BITS)
	) u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_vld     (cf_vld),
		.in_mat     (cf_mat),
		.in_cof_mag (cf_mag),
		.in_cof_neg (cf_neg),
		.in_det     (cf_det),
		.out_vld    (dv_vld),
		.out_mat    (dv_mat),
		.out_zero   (dv_zero),
		.out_neg    (dv_neg),
		.out_ovf    (dv_ovf),
		.out_quo    (dv_quo)
	);

	// sign and clamp per element
	always_comb begin
		for (int l = 0; l < 9; l++) begin
			if (dv_neg[l]) begin
				lane_sat[l] = dv_ovf[l] || (dv_quo[l] > QB'(33'h0_8000_0000));
				res[l] = lane_sat[l] ? 32'h8000_0000 : (32'd0 - dv_quo[l][EW-1:0]);
			end else begin
				lane_sat[l] = dv_ovf[l] || dv_quo[l][QB-1] || dv_quo[l][EW-1];
				res[l] = lane_sat[l] ? 32'h7FFF_FFFF : dv_quo[l][EW-1:0];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			b_q         <= dv_zero ? dv_mat : res;
			singular_q  <= dv_zero;
			saturated_q <= !dv_zero && (lane_sat != '0);
		end
	end

	assign m_tvalid = vld_q;
	assign m_tdata  = b_q;
	assign m_tuser  = {saturated_q, singular_q};

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stream bench for the 3x3 fixed-point matrix inverse core: random and
// directed matrices in, every result compared against a local exact model.
// ----------------------------------------------------------------------------

// Expected inverse results, oldest first
class inverse_board;
	logic [289:0] pending[$];
	int unsigned  errors;
	int unsigned  checked;
	int unsigned  singulars;
	int unsigned  clamps;

	// exact adjugate / determinant with truncation and clamp
	function automatic logic [289:0] predict(logic [287:0] m);
		logic signed [31:0]  e[9];
		logic signed [129:0] cof[9];
		logic signed [129:0] det;
		logic signed [129:0] num;
		logic [129:0]        nmag;
		logic [129:0]        dmag;
		logic [129:0]        q;
		logic [287:0]        res;
		logic                neg;
		logic                sat;
		int                  r0, r1, c0, c1;
		sat = 0;
		for (int k = 0; k < 9; k++) e[k] = m[k*32 +: 32];
		for (int r = 0; r < 3; r++) begin
			r0 = (r == 0) ? 1 : 0;
			r1 = (r == 2) ? 1 : 2;
			for (int c = 0; c < 3; c++) begin
				c0 = (c == 0) ? 1 : 0;
				c1 = (c == 2) ? 1 : 2;
				cof[r*3+c] = 130'(e[r0*3+c0]) * 130'(e[r1*3+c1])
					- 130'(e[r0*3+c1]) * 130'(e[r1*3+c0]);
				if ((r + c) % 2) cof[r*3+c] = -cof[r*3+c];
			end
		end
		det = 130'(e[0]) * cof[0] + 130'(e[1]) * cof[1] + 130'(e[2]) * cof[2];
		if (det == 0) return {2'b01, m};
		dmag = det < 0 ? -det : det;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++) begin
				num  = cof[j*3+i];
				neg  = (num < 0) != (det < 0);
				nmag = (num < 0 ? -num : num) << 32;
				q    = nmag / dmag;
				if (num == 0) res[(i*3+j)*32 +: 32] = 0;
				else if (neg) begin
					if (q > 130'h80000000) begin
						res[(i*3+j)*32 +: 32] = 32'h80000000;
						sat = 1;
					end else res[(i*3+j)*32 +: 32] = -q[31:0];
				end else begin
					if (q > 130'h7FFFFFFF) begin
						res[(i*3+j)*32 +: 32] = 32'h7FFFFFFF;
						sat = 1;
					end else res[(i*3+j)*32 +: 32] = q[31:0];
				end
			end
		return {sat, 1'b0, res};
	endfunction

	function void note_matrix(logic [287:0] m);
		pending.push_back(predict(m));
	endfunction

	function void check_result(logic [287:0] d, logic [1:0] u);
		logic [289:0] exp_r;
		if (pending.size() == 0) begin
			errors++;
			if (errors <= 10) $display("unexpected result %h user %b", d, u);
			return;
		end
		exp_r = pending.pop_front();
		checked++;
		if (exp_r[288]) singulars++;
		if (exp_r[289]) clamps++;
		for (int k = 0; k < 9; k++)
			if (exp_r[k*32 +: 32] !== d[k*32 +: 32]) begin
				errors++;
				if (errors <= 10)
					$display("result %0d element %0d: exp %h got %h",
						checked, k, exp_r[k*32 +: 32], d[k*32 +: 32]);
			end
		if (exp_r[289:288] !== u) begin
			errors++;
			if (errors <= 10)
				$display("result %0d flags: exp %b got %b", checked, exp_r[289:288], u);
		end
	endfunction
endclass

module tb_top;
	import mi3_pkg::*;

	localparam int LATENCY = 40;
	localparam int STALL_LIMIT = 20000;
	localparam logic [31:0] ONE = 32'h00010000;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [287:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [287:0] m_tdata;
	logic [1:0]   m_tuser;

	inverse_board board;
	int  idle_cycles;
	bit  hold_sink;
	bit  done;

	matrix3_inverse_core DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// random 32-bit element, weighted toward small and boundary values
	function automatic logic [31:0] rand_elem();
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: return 32'h80000000 + $urandom_range(0, 3);
			2: return 32'h7FFFFFFF - $urandom_range(0, 3);
			3, 4: return 32'(signed'($urandom_range(0, 8)) - 4) << 16;
			5: return 32'($urandom_range(0, 255)) - 32'd128;
			default: return 32'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
		endcase
	endfunction

	// matrix of random elements, sometimes made singular by a repeated row
	function automatic logic [287:0] rand_matrix();
		logic [287:0] m;
		for (int k = 0; k < 9; k++) m[k*32 +: 32] = rand_elem();
		if ($urandom_range(0, 9) == 0) m[191:96] = m[95:0];
		return m;
	endfunction

	function automatic logic [287:0] diag(logic [31:0] a, logic [31:0] b, logic [31:0] c);
		return {c, 96'd0, b, 96'd0, a};
	endfunction

	// offer one matrix and wait for its transaction; tvalid stays up
	task automatic send_matrix(logic [287:0] m);
		s_tvalid <= 1;
		s_tdata  <= m;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		board.note_matrix(m);
	endtask

	// sender gap with tvalid low, its length set by n
	task automatic idle(int n);
		if (n > 0) begin
			s_tvalid <= 0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic drain();
		if (board.pending.size() != 0) begin
			s_tvalid <= 0;
			while (board.pending.size() != 0) @(posedge clk);
		end
	endtask

	// receiver: own stall pattern, plus a long hold when requested
	initial begin
		m_tready = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_sink) m_tready <= 0;
			else case ($urandom_range(0, 3))
				0: m_tready <= ($urandom_range(0, 3) != 0);
				1: m_tready <= 1;
				default: m_tready <= ($urandom_range(0, 1) != 0);
			endcase
		end
	end

	// result check and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) board.check_result(m_tdata, m_tuser);
			if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (idle_cycles > STALL_LIMIT && !done) begin
				$display("watchdog: no transaction for %0d cycles", idle_cycles);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	initial begin
		int burst;
		board = new();
		idle_cycles = 0;
		hold_sink = 0;
		done = 0;
		s_tvalid = 0;
		s_tdata = '0;
		arst_n = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: identity, scaled, negative, extremes, singular, clamp
		send_matrix(diag(ONE, ONE, ONE));
		send_matrix(diag(ONE << 1, -ONE, ONE >> 1));
		send_matrix(diag(32'h80000000, 32'h80000000, 32'h80000000));
		send_matrix(diag(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF));
		send_matrix(diag(32'd1, 32'd1, 32'd1));
		send_matrix(diag(32'd1, ONE, ONE));
		send_matrix(diag(32'hFFFFFFFF, ONE, ONE));
		send_matrix('0);
		send_matrix({288{1'b1}});
		send_matrix({9{32'h80000000}});
		send_matrix({9{32'h7FFFFFFF}});
		send_matrix({ONE, ONE, 32'd0, 32'd0, ONE, ONE, ONE, 32'd0, ONE});
		send_matrix({ONE, -ONE, ONE, ONE, ONE, -ONE, -ONE, ONE, ONE});
		send_matrix({32'd0, ONE, 32'd0, 32'd0, 32'd0, ONE, ONE, 32'd0, 32'd0});
		send_matrix({32'h55555555, 32'hAAAAAAAA, 32'h12345678, 32'h0F0F0F0F,
			32'hF0F0F0F0, 32'h33333333, 32'hCCCCCCCC, 32'h7FFFFFFF, 32'h80000000});
		send_matrix(diag(ONE, ONE, 32'd0));
		send_matrix(diag(-ONE, -ONE, -ONE));

		// receiver holds while input keeps coming, so the pipe fills up
		hold_sink = 1;
		fork
			begin
				repeat (300) @(posedge clk);
				hold_sink = 0;
			end
			repeat (80) send_matrix(rand_matrix());
		join
		drain();

		// random bursts with gaps
		for (int n = 0; n < 720; n += burst) begin
			burst = $urandom_range(1, 40);
			for (int k = 0; k < burst; k++) send_matrix(rand_matrix());
			if ($urandom_range(0, 7) == 0) drain();
			else idle($urandom_range(0, 6));
		end

		drain();
		repeat (LATENCY + 10) @(posedge clk);
		done = 1;
		$display("checked %0d inverses: %0d singular, %0d clamped", board.checked,
			board.singulars, board.clamps);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule

@@ sim.f @@
hw/rtl/mi3_pkg.sv
hw/rtl/mi3_cofactor.sv
hw/rtl/mi3_div.sv
hw/rtl/matrix3_inverse_core.sv
bench/tb_top.sv
